### rtl/stq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and codes for the sorted timer event queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [1:0] KIND_REJECTED = 2'd1;
  localparam logic [1:0] KIND_EXPIRED  = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [31:0] delay;
    logic [15:0] tag;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] fired_tag;
    logic [4:0]  pending;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [63:0] expiry;
    logic [15:0] tag;
  } entry_t;

endpackage
`default_nettype wire

### rtl/stq_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stq_mem
// Timer entry store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module stq_mem #(
  parameter int ADDR_W = 4
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [ADDR_W-1:0]     wr_addr,
  input  wire stq_pkg::entry_t       wr_entry,
  input  wire logic                  rd_en,
  input  wire logic [ADDR_W-1:0]     rd_addr,
  output stq_pkg::entry_t            rd_entry
);

  stq_pkg::entry_t mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/stq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stq_ctrl
// Sequencer for sorted insert and head drain over a circular entry store,
// sharing one 64-bit adder and one 64-bit compare.
// ----------------------------------------------------------------------------
module stq_ctrl #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int OCC_W  = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire stq_pkg::req_t     req,
  output logic                   emit_valid,
  input  wire logic              emit_ready,
  output stq_pkg::rsp_t          res,
  output logic                   wr_en,
  output logic [ADDR_W-1:0]      wr_addr,
  output stq_pkg::entry_t        wr_entry,
  output logic                   rd_en,
  output logic [ADDR_W-1:0]      rd_addr,
  input  wire stq_pkg::entry_t   rd_entry
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INS   = 3'd1;
  localparam logic [2:0] ST_INSW  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_NEXT  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]        state, state_next;
  logic [63:0]       now, now_next;
  logic [ADDR_W-1:0] head, head_next;
  logic [OCC_W-1:0]  occ, occ_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [63:0]       exp_new, exp_new_next;
  logic [15:0]       tag_new, tag_new_next;
  stq_pkg::rsp_t     res_next;
  logic              ret_drain, ret_drain_next;

  // shared arithmetic
  logic [63:0] add_b;
  logic [63:0] sum;
  logic [63:0] cmp_ref;
  logic        key_le;

  assign add_b   = (req.req_type == stq_pkg::REQ_TICK) ? 64'd1 : 64'(req.delay);
  assign sum     = now + add_b;
  assign cmp_ref = (state == ST_INS) ? exp_new : now;
  assign key_le  = (rd_entry.expiry <= cmp_ref);

  assign req_ready  = (state == ST_IDLE);
  assign emit_valid = (state == ST_EMIT);

  always_comb begin
    state_next     = state;
    now_next       = now;
    head_next      = head;
    occ_next       = occ;
    idx_next       = idx;
    exp_new_next   = exp_new;
    tag_new_next   = tag_new;
    res_next       = res;
    ret_drain_next = ret_drain;
    wr_en          = 1'b0;
    wr_addr        = ADDR_W'(head + idx + ADDR_W'(1));
    wr_entry       = '{expiry: exp_new, tag: tag_new};
    rd_en          = 1'b0;
    rd_addr        = ADDR_W'(head + idx);

    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req.req_type == stq_pkg::REQ_ADD) begin
            if (occ >= OCC_W'(DEPTH)) begin
              res_next = '{kind: stq_pkg::KIND_REJECTED, fired_tag: req.tag,
                           pending: 5'(occ), last: 1'b1};
              ret_drain_next = 1'b0;
              state_next     = ST_EMIT;
            end else begin
              exp_new_next = sum;
              tag_new_next = req.tag;
              if (occ == '0) begin
                state_next = ST_INSW;
              end else begin
                // walk back from the tail
                idx_next   = ADDR_W'(occ - OCC_W'(1));
                rd_en      = 1'b1;
                rd_addr    = ADDR_W'(head + ADDR_W'(occ - OCC_W'(1)));
                state_next = ST_INS;
              end
            end
          end else begin
            now_next = sum;
            if (occ != '0) begin
              rd_en      = 1'b1;
              rd_addr    = head;
              state_next = ST_DRAIN;
            end
          end
        end
      end

      ST_INS: begin
        wr_en = 1'b1;
        if (!key_le) begin
          // later expiry moves up one slot
          wr_entry = rd_entry;
          if (idx == '0) begin
            state_next = ST_INSW;
          end else begin
            idx_next   = ADDR_W'(idx - ADDR_W'(1));
            rd_en      = 1'b1;
            rd_addr    = ADDR_W'(head + idx - ADDR_W'(1));
          end
        end else begin
          occ_next = OCC_W'(occ + OCC_W'(1));
          res_next = '{kind: stq_pkg::KIND_ACCEPTED, fired_tag: tag_new,
                       pending: 5'(occ + OCC_W'(1)), last: 1'b1};
          ret_drain_next = 1'b0;
          state_next     = ST_EMIT;
        end
      end

      ST_INSW: begin
        wr_en    = 1'b1;
        wr_addr  = head;
        occ_next = OCC_W'(occ + OCC_W'(1));
        res_next = '{kind: stq_pkg::KIND_ACCEPTED, fired_tag: tag_new,
                     pending: 5'(occ + OCC_W'(1)), last: 1'b1};
        ret_drain_next = 1'b0;
        state_next     = ST_EMIT;
      end

      ST_DRAIN: begin
        if (key_le) begin
          head_next = ADDR_W'(head + ADDR_W'(1));
          occ_next  = OCC_W'(occ - OCC_W'(1));
          res_next  = '{kind: stq_pkg::KIND_EXPIRED, fired_tag: rd_entry.tag,
                        pending: 5'(occ - OCC_W'(1)), last: 1'b1};
          if (occ == OCC_W'(1)) begin
            ret_drain_next = 1'b0;
            state_next     = ST_EMIT;
          end else begin
            // look ahead to learn whether this beat is the last
            rd_en      = 1'b1;
            rd_addr    = ADDR_W'(head + ADDR_W'(1));
            state_next = ST_NEXT;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end

      ST_NEXT: begin
        res_next.last  = !key_le;
        ret_drain_next = key_le;
        state_next     = ST_EMIT;
      end

      ST_EMIT: begin
        if (emit_ready) begin
          state_next = ret_drain ? ST_DRAIN : ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      now   <= '0;
      head  <= '0;
      occ   <= '0;
    end else begin
      state <= state_next;
      now   <= now_next;
      head  <= head_next;
      occ   <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    exp_new   <= exp_new_next;
    tag_new   <= tag_new_next;
    res       <= res_next;
    ret_drain <= ret_drain_next;
  end

endmodule
`default_nettype wire

### rtl/sorted_timer_event_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_timer_event_queue
// Tick counter plus a queue of pending timers kept sorted by expiry.
//
//   channel | dir | payload         | handshake
//   req     | in  | stq_pkg::req_t  | req_valid / req_ready
//   rsp     | out | stq_pkg::rsp_t  | rsp_valid / rsp_ready
//
// Add: walks back from the tail through the single read port of the entry
// store, moving each queued entry with a later expiry up one slot.
// Tick: each expired timer takes a head read, a look-ahead read for last and
// an emit; the look-ahead is skipped when the queue runs empty.
// Reset clears time, occupancy and head pointer; no sweep.
// A full output register stalls the sequencer; req_ready is low until done.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire stq_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output stq_pkg::rsp_t      rsp
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int OCC_W  = $clog2(DEPTH + 1);

  logic              emit_valid;
  logic              emit_ready;
  stq_pkg::rsp_t     res;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  stq_pkg::entry_t   wr_entry;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  stq_pkg::entry_t   rd_entry;

  stq_ctrl #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .OCC_W  (OCC_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .res        (res),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_entry   (wr_entry),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_entry   (rd_entry)
  );

  stq_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  // output register: free when empty or being drained this cycle
  assign emit_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit_valid && emit_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ready) begin
      rsp <= res;
    end
  end

endmodule
`default_nettype wire

### rtl/stq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stq_checker
// Port-level checks for the sorted timer event queue.
// ----------------------------------------------------------------------------
module stq_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire stq_pkg::req_t req,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire stq_pkg::rsp_t rsp
);

  // a stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp changed while stalled");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.kind == stq_pkg::KIND_ACCEPTED ||
                   rsp.kind == stq_pkg::KIND_REJECTED ||
                   rsp.kind == stq_pkg::KIND_EXPIRED))
    else $error("bad result kind");

  // an add answers with a single beat
  a_add_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.kind == stq_pkg::KIND_ACCEPTED ||
                  rsp.kind == stq_pkg::KIND_REJECTED) |-> rsp.last)
    else $error("add result without last");

  // an accepted add leaves the block busy, with req_ready low
  a_add_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.req_type == stq_pkg::REQ_ADD |=> !req_ready)
    else $error("ready right after add");

endmodule

bind sorted_timer_event_queue stq_checker u_stq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
`default_nettype wire

### dv/sorted_timer_event_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_event_queue_tb
// Drives add and tick requests into the timer queue with random gaps on both
// channels. A local copy of the sorted timer list predicts every response
// beat, and each beat is checked field by field in order of arrival.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue_tb;

  localparam int DEPTH       = 16;
  localparam int HOLD_CYCLES = 300;   // long receiver back-pressure
  localparam int STALL_LIMIT = 3000;  // well above HOLD_CYCLES + one full drain
  localparam int RANDOM_ITEMS = 85;   // per idling phase

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic          req_valid = 1'b0;
  logic          req_ready;
  stq_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  stq_pkg::rsp_t rsp;

  stq_pkg::req_t req_backlog[$];
  stq_pkg::rsp_t upcoming_events[$];

  int req_idle_pct = 0;
  int rsp_idle_pct = 0;
  logic hold_armed = 1'b0;
  logic hold_taken = 1'b0;
  int hold_left    = 0;
  int quiet_cycles = 0;
  int bad_events   = 0;

  // shadow timer list, head first
  logic [63:0] clock_now;
  logic [63:0] expiry_at[DEPTH];
  logic [15:0] tag_at[DEPTH];
  int          timer_count;

  sorted_timer_event_queue #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one accepted request to the shadow list and queues the events it causes.
  task automatic apply_request(input stq_pkg::req_t r);
    stq_pkg::rsp_t ev;
    logic [63:0] expiry;
    int pos;
    int due;
    int i;
    if (r.req_type == stq_pkg::REQ_ADD) begin
      ev.fired_tag = r.tag;
      ev.last      = 1'b1;
      if (timer_count >= DEPTH) begin
        ev.kind    = stq_pkg::KIND_REJECTED;
        ev.pending = timer_count[4:0];
      end else begin
        expiry = clock_now + {32'd0, r.delay};
        pos = 0;
        // equal expiry goes behind: ties leave in arrival order
        while (pos < timer_count && expiry_at[pos] <= expiry) pos++;
        for (i = timer_count; i > pos; i--) begin
          expiry_at[i] = expiry_at[i - 1];
          tag_at[i]    = tag_at[i - 1];
        end
        expiry_at[pos] = expiry;
        tag_at[pos]    = r.tag;
        timer_count++;
        ev.kind    = stq_pkg::KIND_ACCEPTED;
        ev.pending = timer_count[4:0];
      end
      upcoming_events.push_back(ev);
    end else begin
      clock_now = clock_now + 64'd1;
      due = 0;
      while (due < timer_count && expiry_at[due] <= clock_now) due++;
      for (i = 0; i < due; i++) begin
        ev.kind      = stq_pkg::KIND_EXPIRED;
        ev.fired_tag = tag_at[i];
        ev.pending   = 5'(timer_count - i - 1);
        ev.last      = (i == due - 1);
        upcoming_events.push_back(ev);
      end
      for (i = due; i < timer_count; i++) begin
        expiry_at[i - due] = expiry_at[i];
        tag_at[i - due]    = tag_at[i];
      end
      timer_count -= due;
    end
  endtask

  task automatic queue_item(input logic op, input logic [31:0] dly, input logic [15:0] tg);
    stq_pkg::req_t r;
    r.req_type = op;
    r.delay    = dly;
    r.tag      = tg;
    req_backlog.push_back(r);
  endtask

  task automatic queue_random(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99) < 55) begin
        // short delays keep the list busy; a slice of tiny ones makes ties
        if ($urandom_range(99) < 20)
          queue_item(stq_pkg::REQ_ADD, $urandom_range(3),
                     16'($urandom_range(16'hFFFF)));
        else
          queue_item(stq_pkg::REQ_ADD, $urandom_range(24),
                     16'($urandom_range(16'hFFFF)));
      end else begin
        queue_item(stq_pkg::REQ_TICK, $urandom, 16'($urandom_range(16'hFFFF)));
      end
    end
  endtask

  task automatic settle();
    while (req_backlog.size() != 0 || req_valid || upcoming_events.size() != 0)
      @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
        req       <= req_backlog.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // response acceptor, with one long hold-off when armed
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_armed && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      rsp_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
    end
  end

  // monitor: predict on request beats, check on response beats
  always @(posedge clk) begin
    stq_pkg::rsp_t want;
    if (rst) begin
      clock_now   = '0;
      timer_count = 0;
    end else begin
      if (req_valid && req_ready)
        apply_request(req);
      if (rsp_valid && rsp_ready) begin
        if (upcoming_events.size() == 0) begin
          if (bad_events < 10)
            $display("unexpected beat: kind=%0d tag=%h pending=%0d last=%b",
                     rsp.kind, rsp.fired_tag, rsp.pending, rsp.last);
          bad_events++;
        end else begin
          want = upcoming_events.pop_front();
          if (rsp.kind !== want.kind || rsp.fired_tag !== want.fired_tag ||
              rsp.pending !== want.pending || rsp.last !== want.last) begin
            if (bad_events < 10)
              $display({"mismatch at %0t: exp kind=%0d tag=%h pending=%0d last=%b,",
                        " got kind=%0d tag=%h pending=%0d last=%b"},
                       $realtime, want.kind, want.fired_tag, want.pending, want.last,
                       rsp.kind, rsp.fired_tag, rsp.pending, rsp.last);
            bad_events++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int k;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    req_idle_pct = 31;
    rsp_idle_pct = 57;

    // directed: empty tick, zero delay, full list of ties, reject, full drain
    queue_item(stq_pkg::REQ_TICK, 32'd0, 16'h0000);
    queue_item(stq_pkg::REQ_ADD, 32'd0, 16'hFFFF);
    queue_item(stq_pkg::REQ_TICK, 32'hFFFF_FFFF, 16'hFFFF);
    for (k = 0; k < DEPTH; k++)
      queue_item(stq_pkg::REQ_ADD, 32'd2, 16'(k * 16'h1111));
    queue_item(stq_pkg::REQ_ADD, 32'd1, 16'hA5A5);
    queue_item(stq_pkg::REQ_TICK, 32'd0, 16'h0000);
    queue_item(stq_pkg::REQ_TICK, 32'd0, 16'h0000);
    // max delay never fires; later adds all sort in front of it
    queue_item(stq_pkg::REQ_ADD, 32'hFFFF_FFFF, 16'h5A5A);
    queue_item(stq_pkg::REQ_ADD, 32'd1, 16'h0F0F);
    queue_item(stq_pkg::REQ_ADD, 32'd0, 16'hF0F0);
    queue_item(stq_pkg::REQ_TICK, 32'd0, 16'h0000);
    settle();

    queue_random(RANDOM_ITEMS);
    settle();

    req_idle_pct = 57;
    rsp_idle_pct = 31;
    queue_random(RANDOM_ITEMS);
    settle();

    req_idle_pct = 0;
    rsp_idle_pct = 0;
    hold_armed   = 1'b1;
    queue_random(RANDOM_ITEMS);
    settle();

    repeat (60) @(negedge clk);
    if (bad_events == 0 && upcoming_events.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
